// ===== rtl/core/tspt_pkg.sv =====
// Shared widths, codes and helpers of the triangle setup and pixel test block.
`default_nettype none

package tspt_pkg;

    localparam int COORD_BITS = 12;
    localparam int DEPTH_BITS = 16;
    localparam int SHADE_BITS = 16;

    // stream payload layout
    localparam int VTX_W    = 2 * COORD_BITS + DEPTH_BITS;
    localparam int S_DATA_W = 3 * VTX_W + 2 * COORD_BITS;
    localparam int M_BITS   = 3 + DEPTH_BITS + SHADE_BITS;
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

    // plane and edge widths
    localparam int NRM_W = COORD_BITS + 1;
    localparam int A_W   = 32;
    localparam int C_W   = 28;
    localparam int D_W   = 44;

    // serial multiply-accumulate
    localparam int MUL_W = 32;
    localparam int ACC_W = 64;

    // serial divider
    localparam int DIV_NW = 96;
    localparam int DIV_DW = 64;

    // digit-by-digit square root of the shade ratio
    localparam int SQ_STEPS = SHADE_BITS + 1;
    localparam int SQ_IN_W  = 2 * SQ_STEPS;
    localparam int SQ_REM_W = SQ_STEPS + 4;
    localparam int SQ_CNT_W = $clog2(SQ_STEPS + 1);

    localparam int OP_W = 5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_ISSUE,
        ST_LOAD_WAIT,
        ST_QRY_ISSUE,
        ST_QRY_WAIT,
        ST_DIV_ISSUE,
        ST_DIV_WAIT,
        ST_SQRT,
        ST_OUT
    } state_t;

    typedef enum logic [OP_W-1:0] {
        LOP_A0, LOP_A1, LOP_A2,
        LOP_B0, LOP_B1, LOP_B2,
        LOP_C0, LOP_C1, LOP_C2,
        LOP_D0, LOP_D1, LOP_D2,
        LOP_BB, LOP_AA, LOP_CC,
        LOP_N0X, LOP_N0Y, LOP_N1X, LOP_N1Y, LOP_N2X, LOP_N2Y
    } load_op_t;

    typedef enum logic [OP_W-1:0] {
        QOP_E0X, QOP_E0Y, QOP_E1X, QOP_E1Y, QOP_E2X, QOP_E2Y,
        QOP_NA, QOP_NB
    } query_op_t;

    typedef enum logic [1:0] {
        ACC_ZERO,
        ACC_PREV,
        ACC_PLANE_D
    } acc_sel_t;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    function automatic logic [MUL_W-1:0] mag_mul(input logic signed [MUL_W-1:0] v);
        logic signed [MUL_W-1:0] n;
        n = -v;
        return v[MUL_W-1] ? unsigned'(n) : unsigned'(v);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tspt_mac.sv =====
// Bit-serial signed multiply-accumulate: acc_out = acc_in + a * b.
`default_nettype none

module tspt_mac
    import tspt_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [MUL_W-1:0] a,
    input  wire logic signed [MUL_W-1:0] b,
    input  wire logic signed [ACC_W-1:0] acc_in,
    output logic                         done,
    output logic signed [ACC_W-1:0]      acc_out
);

    logic                    busy_reg;
    logic [ACC_W-1:0]        mcand_reg;
    logic [MUL_W-1:0]        mplier_reg;
    logic                    neg_reg;
    logic signed [ACC_W-1:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && mplier_reg == '0) begin
            busy_reg <= 1'b0;
        end
    end

    // consume one multiplier bit per cycle, stop once no set bits remain
    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg  <= ACC_W'(mag_mul(a));
            mplier_reg <= mag_mul(b);
            neg_reg    <= a[MUL_W-1] ^ b[MUL_W-1];
            sum_reg    <= acc_in;
        end else if (busy_reg && mplier_reg != '0) begin
            if (mplier_reg[0]) begin
                sum_reg <= neg_reg ? sum_reg - signed'(mcand_reg)
                                   : sum_reg + signed'(mcand_reg);
            end
            mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[MUL_W-1:1]};
        end
    end

    assign done    = busy_reg && mplier_reg == '0;
    assign acc_out = sum_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tspt_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module tspt_div
    import tspt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIV_NW-1:0] num,
    input  wire logic [DIV_DW-1:0] den,
    output logic                   done,
    output logic [DIV_NW-1:0]      quo
);

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_DW:0]   rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW:0]   rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg[DIV_DW-1:0], quo_reg[DIV_NW-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == '0) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= CNT_W'(DIV_NW);
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg && cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            rem_reg <= fits ? rem_sh - {1'b0, den_reg} : rem_sh;
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
        end
    end

    assign done = busy_reg && cnt_reg == '0;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/triangle_setup_and_pixel_test.sv =====
// Top level of the triangle setup and pixel test block.
// Usage:
//   The slave stream carries one item per transaction. s_tuser is the mode:
//   0 loads a triangle from the vertex fields, 1 tests the pixel in query_x/y.
//   Every item yields exactly one master transaction: in_box, in_triangle,
//   depth, depth_valid and the stored shade.
//   Work is done by a bit-serial multiply-accumulate unit, a restoring divider
//   (one quotient bit a cycle, 96 bits) and a two-bit-a-cycle square root.
//   A multiply step ends once no significant bits of its serial operand
//   remain. A load runs 21 multiply steps, the division and the root (the
//   division and root are skipped when A, B and C are all zero). A query runs
//   8 multiply steps (serial operands of at most 12 significant bits) and,
//   when C is nonzero, the division. One item is in work at a time;
//   s_tready is high only while the sequencer is idle.
//   The finished result sits in an output register, so the next item can be
//   taken while the receiver stalls; the sequencer holds in its output state
//   only if that register is still full when the next result is done.
//   Reset (synchronous, aresetn low) clears the triangle to all zeros and
//   sets the shade to all ones; a query before any load uses that state.
`default_nettype none

module triangle_setup_and_pixel_test
    import tspt_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // vertex1_x, vertex1_y, vertex1_z, vertex2_x, vertex2_y, vertex2_z,
    // vertex3_x, vertex3_y, vertex3_z, query_x, query_y
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // mode
    input  wire logic [0:0]          s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // in_box, in_triangle, depth, depth_valid, shade, zero fill
    output logic [M_DATA_W-1:0]      m_tdata
);

    localparam logic signed [DEPTH_BITS-1:0] DMIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic signed [DEPTH_BITS-1:0] DMAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};

    // ---------------- input field split ----------------
    logic signed [COORD_BITS-1:0] in_x [3];
    logic signed [COORD_BITS-1:0] in_y [3];
    logic signed [DEPTH_BITS-1:0] in_z [3];
    logic signed [COORD_BITS-1:0] in_qx, in_qy;
    logic                         s_accept;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_x[i] = s_tdata[i*VTX_W +: COORD_BITS];
            in_y[i] = s_tdata[i*VTX_W + COORD_BITS +: COORD_BITS];
            in_z[i] = s_tdata[i*VTX_W + 2*COORD_BITS +: DEPTH_BITS];
        end
    end
    assign in_qx    = s_tdata[3*VTX_W +: COORD_BITS];
    assign in_qy    = s_tdata[3*VTX_W + COORD_BITS +: COORD_BITS];
    assign s_accept = s_tvalid && s_tready;

    // ---------------- state ----------------
    state_t                       state_reg, state_next;
    logic [OP_W-1:0]              step_reg, step_next;
    logic                         mode_reg;

    logic signed [COORD_BITS-1:0] x_reg [3];
    logic signed [COORD_BITS-1:0] y_reg [3];
    logic signed [DEPTH_BITS-1:0] z_reg [3];
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic signed [COORD_BITS-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [NRM_W-1:0]      nx_reg [3];
    logic signed [NRM_W-1:0]      ny_reg [3];
    logic signed [A_W-1:0]        a_reg, b_reg;
    logic signed [C_W-1:0]        c_reg;
    logic signed [D_W-1:0]        d_reg;
    logic [SHADE_BITS-1:0]        shade_reg;
    logic [ACC_W-1:0]             bsq_reg, s_reg;
    logic signed [ACC_W-1:0]      acc_reg;

    logic                         box_reg, tri_reg;
    logic signed [DEPTH_BITS-1:0] depth_reg;

    logic [SQ_IN_W-1:0]           sq_n_reg;
    logic [SQ_REM_W-1:0]          sq_rem_reg;
    logic [SQ_STEPS-1:0]          sq_root_reg;
    logic [SQ_CNT_W-1:0]          sq_cnt_reg;

    logic                         m_tvalid_reg;
    logic [M_DATA_W-1:0]          m_tdata_reg;

    // ---------------- unit handshakes ----------------
    logic                         mac_start, mac_done;
    logic signed [MUL_W-1:0]      op_a, op_b;
    acc_sel_t                     acc_sel;
    logic signed [ACC_W-1:0]      mac_acc_in, mac_acc;
    logic                         div_start, div_done;
    logic [DIV_NW-1:0]            div_num, div_quo;
    logic [DIV_DW-1:0]            div_den;
    logic                         out_load;
    logic                         c_nz;

    assign c_nz = c_reg != '0;

    // ---------------- derived edges ----------------
    logic signed [NRM_W-1:0]      ex [3], ey [3];
    logic signed [NRM_W-1:0]      na_pre [3], nb_pre [3];
    logic signed [NRM_W-1:0]      dxm [3], dym [3], qdx [3], qdy [3];
    logic signed [DEPTH_BITS:0]   dz [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            int j, k;
            j = (i == 2) ? 0 : i + 1;
            k = (i == 0) ? 2 : i - 1;
            ex[i]  = NRM_W'(x_reg[j]) - NRM_W'(x_reg[i]);
            ey[i]  = NRM_W'(y_reg[j]) - NRM_W'(y_reg[i]);
            // opposite side differences for the plane coefficients
            dxm[i] = NRM_W'(x_reg[j]) - NRM_W'(x_reg[k]);
            dym[i] = NRM_W'(y_reg[j]) - NRM_W'(y_reg[k]);
            dz[i]  = (DEPTH_BITS+1)'(z_reg[j]) - (DEPTH_BITS+1)'(z_reg[k]);
            qdx[i] = NRM_W'(px_reg) - NRM_W'(x_reg[i]);
            qdy[i] = NRM_W'(py_reg) - NRM_W'(y_reg[i]);
            // perpendicular of the edge pointing to positive x side of dy
            if (ey[i][NRM_W-1]) begin
                na_pre[i] = -ey[i];
                nb_pre[i] = ex[i];
            end else if (ey[i] != '0) begin
                na_pre[i] = ey[i];
                nb_pre[i] = -ex[i];
            end else begin
                na_pre[i] = '0;
                nb_pre[i] = NRM_W'(1);
            end
        end
    end

    // ---------------- bounding box of an incoming load ----------------
    logic signed [COORD_BITS-1:0] bmin_x, bmax_x, bmin_y, bmax_y;
    logic                         hit_box;

    always_comb begin
        bmin_x = in_x[0];
        bmax_x = in_x[0];
        bmin_y = in_y[0];
        bmax_y = in_y[0];
        for (int i = 1; i < 3; i++) begin
            if (in_x[i] < bmin_x) bmin_x = in_x[i];
            if (in_x[i] > bmax_x) bmax_x = in_x[i];
            if (in_y[i] < bmin_y) bmin_y = in_y[i];
            if (in_y[i] > bmax_y) bmax_y = in_y[i];
        end
    end

    assign hit_box = in_qx >= min_x_reg && in_qx <= max_x_reg &&
                     in_qy >= min_y_reg && in_qy <= max_y_reg;

    // ---------------- operand select for the multiply-accumulate ----------------
    always_comb begin
        op_a    = '0;
        op_b    = '0;
        acc_sel = ACC_ZERO;
        if (mode_reg == MODE_LOAD) begin
            unique case (step_reg)
                LOP_A0:  begin op_a = MUL_W'(dz[0]);  op_b = MUL_W'(y_reg[0]); end
                LOP_A1:  begin op_a = MUL_W'(dz[1]);  op_b = MUL_W'(y_reg[1]);
                               acc_sel = ACC_PREV; end
                LOP_A2:  begin op_a = MUL_W'(dz[2]);  op_b = MUL_W'(y_reg[2]);
                               acc_sel = ACC_PREV; end
                LOP_B0:  begin op_a = MUL_W'(z_reg[0]); op_b = MUL_W'(dxm[0]); end
                LOP_B1:  begin op_a = MUL_W'(z_reg[1]); op_b = MUL_W'(dxm[1]);
                               acc_sel = ACC_PREV; end
                LOP_B2:  begin op_a = MUL_W'(z_reg[2]); op_b = MUL_W'(dxm[2]);
                               acc_sel = ACC_PREV; end
                LOP_C0:  begin op_a = MUL_W'(dym[0]); op_b = MUL_W'(x_reg[0]); end
                LOP_C1:  begin op_a = MUL_W'(dym[1]); op_b = MUL_W'(x_reg[1]);
                               acc_sel = ACC_PREV; end
                LOP_C2:  begin op_a = MUL_W'(dym[2]); op_b = MUL_W'(x_reg[2]);
                               acc_sel = ACC_PREV; end
                LOP_D0:  begin op_a = MUL_W'(a_reg); op_b = MUL_W'(x_reg[0]); end
                LOP_D1:  begin op_a = MUL_W'(b_reg); op_b = MUL_W'(y_reg[0]);
                               acc_sel = ACC_PREV; end
                LOP_D2:  begin op_a = MUL_W'(c_reg); op_b = MUL_W'(z_reg[0]);
                               acc_sel = ACC_PREV; end
                LOP_BB:  begin op_a = MUL_W'(b_reg); op_b = MUL_W'(b_reg); end
                LOP_AA:  begin op_a = MUL_W'(a_reg); op_b = MUL_W'(a_reg);
                               acc_sel = ACC_PREV; end
                LOP_CC:  begin op_a = MUL_W'(c_reg); op_b = MUL_W'(c_reg);
                               acc_sel = ACC_PREV; end
                LOP_N0X: begin op_a = MUL_W'(na_pre[0]); op_b = MUL_W'(ex[1]); end
                LOP_N0Y: begin op_a = MUL_W'(nb_pre[0]); op_b = MUL_W'(ey[1]);
                               acc_sel = ACC_PREV; end
                LOP_N1X: begin op_a = MUL_W'(na_pre[1]); op_b = MUL_W'(ex[2]); end
                LOP_N1Y: begin op_a = MUL_W'(nb_pre[1]); op_b = MUL_W'(ey[2]);
                               acc_sel = ACC_PREV; end
                LOP_N2X: begin op_a = MUL_W'(na_pre[2]); op_b = MUL_W'(ex[0]); end
                LOP_N2Y: begin op_a = MUL_W'(nb_pre[2]); op_b = MUL_W'(ey[0]);
                               acc_sel = ACC_PREV; end
                default: begin op_a = '0; op_b = '0; end
            endcase
        end else begin
            unique case (step_reg)
                QOP_E0X: begin op_a = MUL_W'(nx_reg[0]); op_b = MUL_W'(qdx[0]); end
                QOP_E0Y: begin op_a = MUL_W'(ny_reg[0]); op_b = MUL_W'(qdy[0]);
                               acc_sel = ACC_PREV; end
                QOP_E1X: begin op_a = MUL_W'(nx_reg[1]); op_b = MUL_W'(qdx[1]); end
                QOP_E1Y: begin op_a = MUL_W'(ny_reg[1]); op_b = MUL_W'(qdy[1]);
                               acc_sel = ACC_PREV; end
                QOP_E2X: begin op_a = MUL_W'(nx_reg[2]); op_b = MUL_W'(qdx[2]); end
                QOP_E2Y: begin op_a = MUL_W'(ny_reg[2]); op_b = MUL_W'(qdy[2]);
                               acc_sel = ACC_PREV; end
                QOP_NA:  begin op_a = MUL_W'(a_reg); op_b = MUL_W'(px_reg);
                               acc_sel = ACC_PLANE_D; end
                QOP_NB:  begin op_a = MUL_W'(b_reg); op_b = MUL_W'(py_reg);
                               acc_sel = ACC_PREV; end
                default: begin op_a = '0; op_b = '0; end
            endcase
        end
    end

    always_comb begin
        unique case (acc_sel)
            ACC_ZERO:    mac_acc_in = '0;
            ACC_PREV:    mac_acc_in = acc_reg;
            ACC_PLANE_D: mac_acc_in = ACC_W'(d_reg);
            default:     mac_acc_in = '0;
        endcase
    end

    tspt_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start),
        .a       (op_a),
        .b       (op_b),
        .acc_in  (mac_acc_in),
        .done    (mac_done),
        .acc_out (mac_acc)
    );

    // ---------------- divider operands ----------------
    logic [ACC_W-1:0] num_mag;
    logic [C_W-1:0]   c_mag;
    logic             depth_neg;

    assign num_mag   = acc_reg[ACC_W-1] ? unsigned'(-acc_reg) : unsigned'(acc_reg);
    assign c_mag     = c_reg[C_W-1] ? unsigned'(-c_reg) : unsigned'(c_reg);
    assign depth_neg = acc_reg[ACC_W-1] ^ c_reg[C_W-1];

    // load: B^2 scaled by 2^(2*SHADE_BITS) over A^2+B^2+C^2; query: |num| / |C|
    assign div_num = (mode_reg == MODE_LOAD)
                   ? DIV_NW'({bsq_reg, {(2*SHADE_BITS){1'b0}}})
                   : DIV_NW'(num_mag);
    assign div_den = (mode_reg == MODE_LOAD) ? DIV_DW'(s_reg) : DIV_DW'(c_mag);

    tspt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // truncated quotient, saturated to the depth range
    logic                         pos_ovf, neg_ovf;
    logic signed [DEPTH_BITS-1:0] depth_sat;

    assign pos_ovf = |div_quo[DIV_NW-1:DEPTH_BITS-1];
    assign neg_ovf = (|div_quo[DIV_NW-1:DEPTH_BITS]) ||
                     (div_quo[DEPTH_BITS-1] && (|div_quo[DEPTH_BITS-2:0]));

    always_comb begin
        if (depth_neg) begin
            depth_sat = neg_ovf ? DMIN : -signed'(div_quo[DEPTH_BITS-1:0]);
        end else begin
            depth_sat = pos_ovf ? DMAX : signed'(div_quo[DEPTH_BITS-1:0]);
        end
    end

    // ---------------- square root step ----------------
    logic [SQ_REM_W-1:0] sq_rem_sh, sq_trial;
    logic                sq_fits;

    assign sq_rem_sh = {sq_rem_reg[SQ_REM_W-3:0], sq_n_reg[SQ_IN_W-1 -: 2]};
    assign sq_trial  = SQ_REM_W'({sq_root_reg, 2'b01});
    assign sq_fits   = sq_rem_sh >= sq_trial;

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    step_next  = '0;
                    state_next = (s_tuser[0] == MODE_LOAD) ? ST_LOAD_ISSUE : ST_QRY_ISSUE;
                end
            end
            ST_LOAD_ISSUE: state_next = ST_LOAD_WAIT;
            ST_LOAD_WAIT: begin
                if (mac_done) begin
                    if (step_reg == LOP_N2Y) begin
                        state_next = (s_reg == '0) ? ST_OUT : ST_DIV_ISSUE;
                    end else begin
                        step_next  = step_reg + OP_W'(1);
                        state_next = ST_LOAD_ISSUE;
                    end
                end
            end
            ST_QRY_ISSUE: state_next = ST_QRY_WAIT;
            ST_QRY_WAIT: begin
                if (mac_done) begin
                    if (step_reg == QOP_NB) begin
                        state_next = c_nz ? ST_DIV_ISSUE : ST_OUT;
                    end else begin
                        step_next  = step_reg + OP_W'(1);
                        state_next = ST_QRY_ISSUE;
                    end
                end
            end
            ST_DIV_ISSUE: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = (mode_reg == MODE_LOAD) ? ST_SQRT : ST_OUT;
                end
            end
            ST_SQRT: begin
                if (sq_cnt_reg == '0) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        s_tready  = 1'b0;
        mac_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:       s_tready  = 1'b1;
            ST_LOAD_ISSUE: mac_start = 1'b1;
            ST_QRY_ISSUE:  mac_start = 1'b1;
            ST_DIV_ISSUE:  div_start = 1'b1;
            ST_OUT:        out_load  = !m_tvalid_reg || m_tready;
            default:       s_tready  = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // ---------------- triangle state and working registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_LOAD;
            for (int i = 0; i < 3; i++) begin
                x_reg[i]  <= '0;
                y_reg[i]  <= '0;
                z_reg[i]  <= '0;
                nx_reg[i] <= '0;
                ny_reg[i] <= '0;
            end
            px_reg    <= '0;
            py_reg    <= '0;
            min_x_reg <= '0;
            max_x_reg <= '0;
            min_y_reg <= '0;
            max_y_reg <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            c_reg     <= '0;
            d_reg     <= '0;
            shade_reg <= '1;
            bsq_reg   <= '0;
            s_reg     <= '0;
            acc_reg   <= '0;
            box_reg   <= 1'b0;
            tri_reg   <= 1'b0;
            depth_reg <= '0;
        end else begin
            if (s_accept) begin
                mode_reg <= s_tuser[0];
                if (s_tuser[0] == MODE_LOAD) begin
                    for (int i = 0; i < 3; i++) begin
                        x_reg[i] <= in_x[i];
                        y_reg[i] <= in_y[i];
                        z_reg[i] <= in_z[i];
                    end
                    min_x_reg <= bmin_x;
                    max_x_reg <= bmax_x;
                    min_y_reg <= bmin_y;
                    max_y_reg <= bmax_y;
                    box_reg   <= 1'b0;
                    tri_reg   <= 1'b0;
                    depth_reg <= '0;
                end else begin
                    px_reg  <= in_qx;
                    py_reg  <= in_qy;
                    box_reg <= hit_box;
                    tri_reg <= 1'b1;
                end
            end

            // write back each finished multiply step
            if (state_reg == ST_LOAD_WAIT && mac_done) begin
                acc_reg <= mac_acc;
                unique case (step_reg)
                    LOP_A2:  a_reg   <= mac_acc[A_W-1:0];
                    LOP_B2:  b_reg   <= mac_acc[A_W-1:0];
                    LOP_C2:  c_reg   <= mac_acc[C_W-1:0];
                    LOP_D2:  d_reg   <= D_W'(-mac_acc);
                    LOP_BB:  bsq_reg <= unsigned'(mac_acc);
                    LOP_CC:  s_reg   <= unsigned'(mac_acc);
                    LOP_N0Y: begin
                        nx_reg[0] <= mac_acc[ACC_W-1] ? -na_pre[0] : na_pre[0];
                        ny_reg[0] <= mac_acc[ACC_W-1] ? -nb_pre[0] : nb_pre[0];
                    end
                    LOP_N1Y: begin
                        nx_reg[1] <= mac_acc[ACC_W-1] ? -na_pre[1] : na_pre[1];
                        ny_reg[1] <= mac_acc[ACC_W-1] ? -nb_pre[1] : nb_pre[1];
                    end
                    LOP_N2Y: begin
                        nx_reg[2] <= mac_acc[ACC_W-1] ? -na_pre[2] : na_pre[2];
                        ny_reg[2] <= mac_acc[ACC_W-1] ? -nb_pre[2] : nb_pre[2];
                        // flat or degenerate plane: full intensity
                        if (s_reg == '0) shade_reg <= '1;
                    end
                    default: ;
                endcase
            end

            if (state_reg == ST_QRY_WAIT && mac_done) begin
                unique case (step_reg)
                    QOP_E0Y, QOP_E1Y, QOP_E2Y: begin
                        acc_reg <= mac_acc;
                        if (mac_acc[ACC_W-1]) tri_reg <= 1'b0;
                    end
                    QOP_NB: begin
                        // hold the depth numerator -(Ax + By + D)
                        acc_reg <= -mac_acc;
                        if (!c_nz) depth_reg <= DMIN;
                    end
                    default: acc_reg <= mac_acc;
                endcase
            end

            if (state_reg == ST_DIV_WAIT && div_done && mode_reg == MODE_QUERY) begin
                depth_reg <= depth_sat;
            end

            if (state_reg == ST_SQRT && sq_cnt_reg == '0) begin
                shade_reg <= sq_root_reg[SQ_STEPS-1] ? '1 : sq_root_reg[SHADE_BITS-1:0];
            end
        end
    end

    // square root: two radicand bits per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_cnt_reg <= '0;
        end else if (state_reg == ST_DIV_WAIT && div_done) begin
            sq_cnt_reg <= SQ_CNT_W'(SQ_STEPS);
        end else if (state_reg == ST_SQRT && sq_cnt_reg != '0) begin
            sq_cnt_reg <= sq_cnt_reg - SQ_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV_WAIT && div_done) begin
            sq_n_reg    <= div_quo[SQ_IN_W-1:0];
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end else if (state_reg == ST_SQRT && sq_cnt_reg != '0) begin
            sq_n_reg    <= {sq_n_reg[SQ_IN_W-3:0], 2'b00};
            sq_rem_reg  <= sq_fits ? sq_rem_sh - sq_trial : sq_rem_sh;
            sq_root_reg <= {sq_root_reg[SQ_STEPS-2:0], sq_fits};
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= M_DATA_W'({shade_reg, c_nz, depth_reg, tri_reg, box_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_mac_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> (state_reg == ST_LOAD_WAIT || state_reg == ST_QRY_WAIT))
        else $error("multiply step finished outside a wait state");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("division finished outside its wait state");

    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser[0] == MODE_LOAD) |=> state_reg == ST_LOAD_ISSUE)
        else $error("accepted load did not start setup");

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(m_tdata_reg))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
